FILE: rtl/assert_macros.svh
// Assertion macros shared by the residue reachability RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SSRR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssrr assertion failed");
`define SSRR_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ssrr forbidden condition seen");
`else
`define SSRR_ASSERT(label, clk, rst, prop)
`define SSRR_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: rtl/ssrr_pkg.sv
// Package for the signed sum residue reachability core: sizes, types, helpers.
// No dependencies; used by every module and interface file.
`timescale 1ns / 1ps

package ssrr_pkg;

  localparam int MAX_MODULUS = 128;
  localparam int CFG_W       = 8;
  localparam int VAL_W       = 16;
  localparam int K_W         = $clog2(MAX_MODULUS + 1);
  localparam int RES_W       = $clog2(MAX_MODULUS);
  localparam int DUAL_W      = 2 * MAX_MODULUS;
  localparam int CNT_W       = $clog2(VAL_W);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CALC,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [RES_W-1:0] residue;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  function automatic logic [K_W-1:0] eff_modulus(input logic [CFG_W-1:0] m);
    logic [K_W-1:0] k;
    if (m == '0) begin
      k = K_W'(1);
    end else if (int'(m) > MAX_MODULUS) begin
      k = K_W'(MAX_MODULUS);
    end else begin
      k = K_W'(m);
    end
    return k;
  endfunction

endpackage

FILE: rtl/ssrr_if.sv
// Valid/ready channel interfaces for input terms and divisibility results.
// Depends on ssrr_pkg for the term width.
`timescale 1ns / 1ps

interface ssrr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [ssrr_pkg::VAL_W-1:0] value;
  logic                             last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface ssrr_out_if;
  logic valid;
  logic ready;
  logic divisible;

  modport source (output valid, output divisible, input ready);
  modport sink (input valid, input divisible, output ready);
endinterface

FILE: rtl/ssrr_front.sv
// Front end: accepts terms and reduces each one to its residue modulo k.
// Depends on ssrr_pkg, ssrr_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssrr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ssrr_pkg::CFG_W-1:0]  modulus,
  ssrr_in_if.sink                     sample,
  input  logic                        full,
  output ssrr_pkg::slot_t             push
);

  ssrr_pkg::front_state_t state, state_next;

  logic                          neg;
  logic                          last;
  logic [ssrr_pkg::VAL_W-1:0]    mag;
  logic [ssrr_pkg::RES_W-1:0]    rem;
  logic [ssrr_pkg::K_W-1:0]      k;
  logic [ssrr_pkg::CNT_W-1:0]    cnt;
  logic [ssrr_pkg::K_W-1:0]      trial;
  logic [ssrr_pkg::RES_W-1:0]    step_rem;
  logic [ssrr_pkg::RES_W-1:0]    residue;
  logic                          accept;

  assign accept = sample.valid && sample.ready;
  assign trial  = {rem, mag[ssrr_pkg::VAL_W-1]};

  always_comb begin
    if (trial >= k) begin
      step_rem = ssrr_pkg::RES_W'(trial - k);
    end else begin
      step_rem = ssrr_pkg::RES_W'(trial);
    end
    if (neg && rem != '0) begin
      residue = ssrr_pkg::RES_W'(k - ssrr_pkg::K_W'(rem));
    end else begin
      residue = rem;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssrr_pkg::FS_IDLE: begin
        if (accept) state_next = ssrr_pkg::FS_CALC;
      end
      ssrr_pkg::FS_CALC: begin
        if (cnt == ssrr_pkg::CNT_W'(ssrr_pkg::VAL_W - 1)) state_next = ssrr_pkg::FS_PUSH;
      end
      ssrr_pkg::FS_PUSH: begin
        if (!full) state_next = ssrr_pkg::FS_IDLE;
      end
      default: state_next = ssrr_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    sample.ready        = 1'b0;
    push.valid          = 1'b0;
    push.entry.k        = k;
    push.entry.residue  = residue;
    push.entry.last     = last;
    unique case (state)
      ssrr_pkg::FS_IDLE: sample.ready = 1'b1;
      ssrr_pkg::FS_CALC: sample.ready = 1'b0;
      ssrr_pkg::FS_PUSH: push.valid   = 1'b1;
      default:           sample.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssrr_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg  <= sample.value[ssrr_pkg::VAL_W-1];
      mag  <= sample.value[ssrr_pkg::VAL_W-1] ? ssrr_pkg::VAL_W'(-sample.value)
                                               : ssrr_pkg::VAL_W'(sample.value);
      last <= sample.last;
      k    <= ssrr_pkg::eff_modulus(modulus);
      rem  <= '0;
      cnt  <= '0;
    end else if (state == ssrr_pkg::FS_CALC) begin
      rem  <= step_rem;
      mag  <= mag << 1;
      cnt  <= cnt + ssrr_pkg::CNT_W'(1);
    end
  end

  `SSRR_ASSERT(a_residue_lt_k, clk, rst, push.valid |-> (ssrr_pkg::K_W'(push.entry.residue) < push.entry.k))
  `SSRR_ASSERT(a_accept_starts, clk, rst, accept |=> (state == ssrr_pkg::FS_CALC && cnt == '0 && rem == '0))
  `SSRR_ASSERT(a_k_nonzero, clk, rst, (state != ssrr_pkg::FS_IDLE) |-> (k != '0))

endmodule

FILE: rtl/ssrr_queue.sv
// Two-word queue between the residue front end and the set update back end.
// Depends on ssrr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssrr_queue (
  input  logic             clk,
  input  logic             rst,
  input  ssrr_pkg::slot_t  push,
  output logic             full,
  output ssrr_pkg::slot_t  pop,
  input  logic             pop_ready
);

  ssrr_pkg::entry_t              store [ssrr_pkg::QDEPTH];
  logic [ssrr_pkg::QPTR_W-1:0]   wptr;
  logic [ssrr_pkg::QPTR_W-1:0]   rptr;
  logic [ssrr_pkg::QCNT_W-1:0]   count;
  logic                          push_fire;
  logic                          pop_fire;

  assign full      = (count == ssrr_pkg::QCNT_W'(ssrr_pkg::QDEPTH));
  assign pop.valid = (count != '0);
  assign pop.entry = store[rptr];
  assign push_fire = push.valid && !full;
  assign pop_fire  = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) store[wptr] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wptr <= (wptr == ssrr_pkg::QPTR_W'(ssrr_pkg::QDEPTH - 1)) ? '0
                                                                   : wptr + ssrr_pkg::QPTR_W'(1);
      end
      if (pop_fire) begin
        rptr <= (rptr == ssrr_pkg::QPTR_W'(ssrr_pkg::QDEPTH - 1)) ? '0
                                                                   : rptr + ssrr_pkg::QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + ssrr_pkg::QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - ssrr_pkg::QCNT_W'(1);
      end
    end
  end

  `SSRR_NEVER(a_count_bound, clk, rst, count > ssrr_pkg::QCNT_W'(ssrr_pkg::QDEPTH))
  `SSRR_ASSERT(a_push_grows, clk, rst, (push_fire && !pop_fire) |=> (count == $past(count) + ssrr_pkg::QCNT_W'(1)))
  `SSRR_ASSERT(a_full_holds, clk, rst, (full && !pop_fire) |=> full)

endmodule

FILE: rtl/ssrr_back.sv
// Back end: updates the reachable residue set and registers the result word.
// Depends on ssrr_pkg, ssrr_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssrr_back (
  input  logic             clk,
  input  logic             rst,
  input  ssrr_pkg::slot_t  slot,
  output logic             pop_ready,
  ssrr_out_if.source       result
);

  logic [ssrr_pkg::MAX_MODULUS-1:0] reach;
  logic [ssrr_pkg::MAX_MODULUS-1:0] reach_next;
  logic [ssrr_pkg::MAX_MODULUS-1:0] kmask;
  logic [ssrr_pkg::MAX_MODULUS-1:0] rm;
  logic [ssrr_pkg::MAX_MODULUS-1:0] up;
  logic [ssrr_pkg::MAX_MODULUS-1:0] dn;
  logic [ssrr_pkg::MAX_MODULUS-1:0] first_set;
  logic [ssrr_pkg::DUAL_W-1:0]      dual;
  logic [ssrr_pkg::DUAL_W-1:0]      dual_up;
  logic [ssrr_pkg::DUAL_W-1:0]      dual_dn;
  logic [ssrr_pkg::K_W-1:0]         up_sh;
  logic                             started;
  logic                             out_valid;
  logic                             divisible;
  logic                             fire;

  assign pop_ready        = !out_valid || result.ready;
  assign fire             = slot.valid && pop_ready;
  assign result.valid     = out_valid;
  assign result.divisible = divisible;

  always_comb begin
    for (int t = 0; t < ssrr_pkg::MAX_MODULUS; t++) begin
      kmask[t] = (t < int'(slot.entry.k));
    end
  end

  always_comb begin
    rm        = reach & kmask;
    dual      = {ssrr_pkg::MAX_MODULUS'(0), rm}
              | ({ssrr_pkg::MAX_MODULUS'(0), rm} << slot.entry.k);
    up_sh     = slot.entry.k - ssrr_pkg::K_W'(slot.entry.residue);
    dual_up   = dual >> up_sh;
    dual_dn   = dual >> slot.entry.residue;
    up        = dual_up[ssrr_pkg::MAX_MODULUS-1:0] & kmask;
    dn        = dual_dn[ssrr_pkg::MAX_MODULUS-1:0] & kmask;
    first_set = ssrr_pkg::MAX_MODULUS'(1) << slot.entry.residue;
    reach_next = started ? (up | dn) : first_set;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reach     <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        reach   <= reach_next;
        started <= !slot.entry.last;
      end
      if (fire && slot.entry.last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && slot.entry.last) divisible <= reach_next[0];
  end

  `SSRR_ASSERT(a_first_onehot, clk, rst, (fire && !started) |=> $onehot(reach))
  `SSRR_ASSERT(a_last_ends, clk, rst, (fire && slot.entry.last) |=> (!started && result.valid))
  `SSRR_ASSERT(a_set_in_range, clk, rst, fire |=> ((reach & ~$past(kmask)) == '0))

endmodule

FILE: rtl/signed_sum_residue_reachability_core.sv
// One result word per last term; the back end folds each queued residue into the set.
// The front end takes no new word until its bit-per-cycle remainder loop has run
// (16 steps) and handed the residue to the queue.
// The back end updates the residue set behind a two-word queue and registers the result.
// Reset: synchronous, active high; clears control, the residue set and sets the modulus to 1.
`timescale 1ns / 1ps

module signed_sum_residue_reachability_core (
  input  logic                        clk,
  input  logic                        rst,
  ssrr_in_if.sink                     sample,
  ssrr_out_if.source                  result,
  input  logic                        cfg_we,
  input  logic [ssrr_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [ssrr_pkg::CFG_W-1:0] modulus;
  ssrr_pkg::slot_t            push;
  ssrr_pkg::slot_t            pop;
  logic                       full;
  logic                       pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ssrr_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  ssrr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .sample  (sample),
    .full    (full),
    .push    (push)
  );

  ssrr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pop       (pop),
    .pop_ready (pop_ready)
  );

  ssrr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .slot      (pop),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule

FILE: tb/ssrr_checker.sv
// Checker for the signed sum residue reachability core: predicts divisibility words.
// Depends on ssrr_pkg and the channel interfaces in ssrr_if; instantiated by tb.
`timescale 1ns / 1ps

module ssrr_checker (
  input  logic                       clk,
  input  logic                       rst,
  ssrr_in_if                         sample,
  ssrr_out_if                        result,
  input  logic                       cfg_we,
  input  logic [ssrr_pkg::CFG_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         pending,
  output int                         words_seen,
  output int                         results_seen
);
  import ssrr_pkg::*;

  logic [CFG_W-1:0]       modulus_reg;
  logic [MAX_MODULUS-1:0] reach_set;
  logic                   seq_open;
  logic                   divisible_q[$];

  function automatic int unsigned active_k(input logic [CFG_W-1:0] m);
    if (m == '0) begin
      return 1;
    end
    if (int'(m) > MAX_MODULUS) begin
      return MAX_MODULUS;
    end
    return int'(m);
  endfunction

  function automatic int unsigned term_residue(input logic signed [VAL_W-1:0] v,
                                               input int unsigned k);
    int m;
    m = int'(v) % int'(k);
    if (m < 0) begin
      m += int'(k);
    end
    return m;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    int unsigned            k;
    int unsigned            r;
    int unsigned            up;
    int unsigned            dn;
    logic [MAX_MODULUS-1:0] nxt;
    logic                   want;
    if (rst) begin
      modulus_reg  = CFG_W'(1);
      reach_set    = '0;
      seq_open     = 1'b0;
      mismatches   = 0;
      words_seen   = 0;
      results_seen = 0;
      divisible_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (divisible_q.size() == 0) begin
          flag($sformatf("unexpected result word: divisible=%0b", result.divisible));
        end else begin
          want = divisible_q.pop_front();
          if (result.divisible !== want) begin
            flag($sformatf("divisible mismatch: expected %0b, got %0b",
                           want, result.divisible));
          end
        end
      end
      if (sample.valid && sample.ready) begin
        words_seen++;
        k = active_k(modulus_reg);
        r = term_residue(sample.value, k);
        if (!seq_open) begin
          reach_set    = '0;
          reach_set[r] = 1'b1;
          seq_open     = 1'b1;
        end else begin
          nxt = '0;
          for (int s = 0; s < k; s++) begin
            if (reach_set[s]) begin
              up = s + r;
              dn = s + k - r;
              if (up >= k) up -= k;
              if (dn >= k) dn -= k;
              nxt[up] = 1'b1;
              nxt[dn] = 1'b1;
            end
          end
          reach_set = nxt;
        end
        if (sample.last) begin
          divisible_q.push_back(reach_set[0]);
          seq_open = 1'b0;
        end
      end
      if (cfg_we) begin
        modulus_reg = cfg_wdata;
      end
    end
    pending = divisible_q.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the residue reachability regression: clock, reset, stimulus and verdict.
// Depends on ssrr_pkg, ssrr_if, the core under test and ssrr_checker.
`timescale 1ns / 1ps

module tb;
  import ssrr_pkg::*;

  localparam int RANDOM_WORDS   = 1900;
  localparam int PHASE_WORDS    = 160;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 500;
  localparam int WATCHDOG_LIMIT = 4000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int words_seen;
  int results_seen;
  int idle_cycles;
  int settings_used;
  bit calm;
  bit hold_off_req;

  ssrr_in_if  sample_ch ();
  ssrr_out_if result_ch ();

  signed_sum_residue_reachability_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ssrr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample_ch),
    .result       (result_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .words_seen   (words_seen),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_ch.ready <= calm || ($urandom_range(99, 0) >= 32);
      end
    end
  end

  task automatic send_word(input int v, input logic is_last);
    while (!calm && $urandom_range(99, 0) < 32) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.value <= VAL_W'(v);
    sample_ch.last  <= is_last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every result is in and the core has settled
  task automatic await_idle();
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [CFG_W-1:0] m);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int rand_term(input logic [CFG_W-1:0] m);
    int base;
    int v;
    base = (m == '0) ? 1 : int'(m);
    case ($urandom_range(9, 0))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3: v = -1;
      4, 5: begin
        v = base * int'($urandom_range(32767 / base, 0));
        if ($urandom_range(1, 0) == 1) v = -v;
      end
      6: v = int'($urandom_range(2 * base, 0)) - base;
      default: v = int'($signed(16'($urandom())));
    endcase
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_modulus();
    logic [CFG_W-1:0] picks[16] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd8, 8'd13,
                                    8'd64, 8'd100, 8'd127, 8'd128, 8'd129, 8'd200,
                                    8'd255, 8'd6};
    if ($urandom_range(3, 0) == 0) begin
      return CFG_W'($urandom());
    end
    return picks[$urandom_range(15, 0)];
  endfunction

  initial begin
    logic [CFG_W-1:0] m;
    int               random_sent;
    int               phase;
    int               n;
    int               len;
    bit               leave_open;
    sample_ch.valid = 1'b0;
    sample_ch.value = '0;
    sample_ch.last  = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    calm            = 1'b0;
    hold_off_req    = 1'b0;
    settings_used   = 0;
    rst             = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset modulus, extremes, saturation, zero modulus, mid-sequence change
    send_word(5, 1'b1);
    write_modulus(8'd7);
    send_word(7, 1'b1);
    send_word(3, 1'b1);
    send_word(-32768, 1'b1);
    send_word(32767, 1'b1);
    send_word(3, 1'b0);
    send_word(4, 1'b1);
    send_word(-5, 1'b0);
    send_word(2, 1'b0);
    send_word(32767, 1'b0);
    send_word(-32768, 1'b1);
    write_modulus(8'd0);
    send_word(-1, 1'b0);
    send_word(12345, 1'b1);
    write_modulus(8'd255);
    send_word(100, 1'b0);
    send_word(-28, 1'b1);
    send_word(-32768, 1'b1);
    write_modulus(8'd128);
    send_word(0, 1'b1);
    send_word(-129, 1'b0);
    send_word(1, 1'b1);
    write_modulus(8'd6);
    send_word(4, 1'b0);
    send_word(5, 1'b0);
    write_modulus(8'd5);
    send_word(1, 1'b1);

    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_WORDS) begin
      m = pick_modulus();
      write_modulus(m);
      calm = (phase == 3);
      if (phase == 1) begin
        hold_off_req = 1'b1;
        repeat (30) begin
          send_word(rand_term(m), 1'b1);
          random_sent++;
        end
      end
      n = 0;
      while (n < PHASE_WORDS) begin
        len        = ($urandom_range(3, 0) == 0) ? 1 : int'($urandom_range(8, 2));
        leave_open = (n + len >= PHASE_WORDS) && ($urandom_range(3, 0) == 0);
        for (int i = 0; i < len; i++) begin
          send_word(rand_term(m), (i == len - 1) && !leave_open);
        end
        n += len;
      end
      random_sent += n;
      calm = 1'b0;
      phase++;
    end

    await_idle();
    $display("Covered %0d words and %0d divisibility results over %0d modulus settings,",
             words_seen, results_seen, settings_used);
    $display("including zero, saturating and mid-sequence modulus changes and a long stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
